@@ design/i2cmbe_pkg.sv @@
package i2cmbe_pkg;

    // bus phase of the bit engine
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_WLOW,
        PH_WRISE,
        PH_WHIGH,
        PH_RLOW,
        PH_RRISE,
        PH_RHIGH,
        PH_STOP_LOW,
        PH_STOP_RISE,
        PH_STOP_HIGH,
        PH_STOP_END,
        PH_REC_LOW,
        PH_REC_HIGH
    } phase_t;

    // command codes
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_WRITE    = 3'd2;
    localparam logic [2:0] CMD_READ     = 3'd3;
    localparam logic [2:0] CMD_STOP     = 3'd4;
    localparam logic [2:0] CMD_STOP_REC = 3'd5;
    localparam logic [2:0] CMD_RSVD_6   = 3'd6;
    localparam logic [2:0] CMD_RSVD_7   = 3'd7;

    // configuration register indexes
    localparam logic [1:0] REG_HALF_PERIOD     = 2'd0;
    localparam logic [1:0] REG_STRETCH_LIMIT   = 2'd1;
    localparam logic [1:0] REG_RECOVERY_PULSES = 2'd2;

    // configuration reset values
    localparam logic [7:0] HALF_PERIOD_RST     = 8'd18;
    localparam logic [7:0] STRETCH_LIMIT_RST   = 8'd200;
    localparam logic [3:0] RECOVERY_PULSES_RST = 4'd10;

    // bits per byte before the acknowledge slot
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

@@ design/i2c_master_bit_engine.sv @@
// i2c master bit engine: one timing tick per input beat, one status beat per tick
// output: the status beat for a tick is registered and presented in the cycle after the tick is taken
// throughput: one tick per cycle; a tick is taken whenever the output register
//   is empty or being drained, and the engine state advances in the accepting cycle
// reset: rst_n clears the engine to idle with both lines released and loads the
//   default half period, stretch limit and recovery pulse count
module i2c_master_bit_engine
(
    input  logic        clk,
    input  logic        rst_n,

    // tick input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [6:0] device_address, [7] read_dir, [15:8] data_byte, [16] send_nack,
    // [17] sda_in, [18] scl_in, [23:19] zero
    input  logic [23:0] s_axis_tdata,
    // [2:0] command
    input  logic [2:0]  s_axis_tuser,

    // status output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] sda_pull_low, [1] scl_pull_low, [2] busy_res, [3] done_res,
    // [11:4] read_data, [12] ack_bit, [13] line_busy_error, [15:14] zero
    output logic [15:0] m_axis_tdata,

    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // configuration registers
    logic [7:0] half_period_reg;
    logic [7:0] stretch_limit_reg;
    logic [3:0] recovery_pulses_reg;

    // engine state
    i2cmbe_pkg::phase_t phase_reg, phase_next;
    logic [7:0] delay_count_reg, delay_count_next;
    logic [7:0] stretch_count_reg, stretch_count_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_data_reg, shift_data_next;
    logic [3:0] recover_count_reg, recover_count_next;
    logic [2:0] active_command_reg, active_command_next;
    logic       nack_latch_reg, nack_latch_next;
    logic       sda_drive_reg, sda_drive_next;
    logic       scl_drive_reg, scl_drive_next;
    logic       last_ack_reg, last_ack_next;
    logic       busy_error_reg, busy_error_next;
    logic [7:0] rx_hold_reg, rx_hold_next;
    logic       done_next;

    // output register
    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    // tick fields
    logic [2:0] command;
    logic [6:0] device_address;
    logic       read_dir;
    logic [7:0] data_byte;
    logic       send_nack;
    logic       sda_in;
    logic       scl_in;

    logic       in_accept;
    logic [7:0] short_load;
    logic       enter_en;
    i2cmbe_pkg::phase_t enter_ph;
    logic       wbit;

    assign command        = s_axis_tuser;
    assign device_address = s_axis_tdata[6:0];
    assign read_dir       = s_axis_tdata[7];
    assign data_byte      = s_axis_tdata[15:8];
    assign send_nack      = s_axis_tdata[16];
    assign sda_in         = s_axis_tdata[17];
    assign scl_in         = s_axis_tdata[18];

    // handshakes
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign cfg_ready     = 1'b1;

    // shortened phase length, one tick less than the half period
    assign short_load = (half_period_reg != 8'd0) ? (half_period_reg - 8'd1) : 8'd0;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg     <= i2cmbe_pkg::HALF_PERIOD_RST;
            stretch_limit_reg   <= i2cmbe_pkg::STRETCH_LIMIT_RST;
            recovery_pulses_reg <= i2cmbe_pkg::RECOVERY_PULSES_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                i2cmbe_pkg::REG_HALF_PERIOD:     half_period_reg     <= cfg_data;
                i2cmbe_pkg::REG_STRETCH_LIMIT:   stretch_limit_reg   <= cfg_data;
                i2cmbe_pkg::REG_RECOVERY_PULSES: recovery_pulses_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // next engine state for one tick
    always_comb
    begin
        phase_next          = phase_reg;
        delay_count_next    = delay_count_reg;
        stretch_count_next  = stretch_count_reg;
        bit_count_next      = bit_count_reg;
        shift_data_next     = shift_data_reg;
        recover_count_next  = recover_count_reg;
        active_command_next = active_command_reg;
        nack_latch_next     = nack_latch_reg;
        sda_drive_next      = sda_drive_reg;
        scl_drive_next      = scl_drive_reg;
        last_ack_next       = last_ack_reg;
        busy_error_next     = busy_error_reg;
        rx_hold_next        = rx_hold_reg;
        done_next           = 1'b0;
        enter_en            = 1'b0;
        enter_ph            = i2cmbe_pkg::PH_IDLE;
        wbit                = 1'b0;

        unique case (phase_reg)
            // command decode while idle
            i2cmbe_pkg::PH_IDLE:
            begin
                case (command)
                    i2cmbe_pkg::CMD_START:
                    begin
                        sda_drive_next = 1'b0;
                        scl_drive_next = 1'b0;
                        if (!sda_in)
                        begin
                            busy_error_next = 1'b1;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            busy_error_next     = 1'b0;
                            active_command_next = i2cmbe_pkg::CMD_START;
                            shift_data_next     = {device_address, read_dir};
                            enter_en            = 1'b1;
                            enter_ph            = i2cmbe_pkg::PH_START_A;
                        end
                    end
                    i2cmbe_pkg::CMD_WRITE:
                    begin
                        active_command_next = i2cmbe_pkg::CMD_WRITE;
                        shift_data_next     = data_byte;
                        bit_count_next      = 4'd0;
                        enter_en            = 1'b1;
                        enter_ph            = i2cmbe_pkg::PH_WLOW;
                    end
                    i2cmbe_pkg::CMD_READ:
                    begin
                        active_command_next = i2cmbe_pkg::CMD_READ;
                        nack_latch_next     = send_nack;
                        shift_data_next     = 8'd0;
                        bit_count_next      = 4'd0;
                        enter_en            = 1'b1;
                        enter_ph            = i2cmbe_pkg::PH_RLOW;
                    end
                    i2cmbe_pkg::CMD_STOP, i2cmbe_pkg::CMD_STOP_REC:
                    begin
                        active_command_next = command;
                        recover_count_next  = 4'd0;
                        enter_en            = 1'b1;
                        enter_ph            = i2cmbe_pkg::PH_STOP_LOW;
                    end
                    default: ;
                endcase
            end

            // clock stretch waits
            i2cmbe_pkg::PH_WRISE, i2cmbe_pkg::PH_RRISE, i2cmbe_pkg::PH_STOP_RISE:
            begin
                if (!scl_in && (stretch_count_reg < stretch_limit_reg))
                begin
                    stretch_count_next = stretch_count_reg + 8'd1;
                end
                else
                begin
                    enter_en = 1'b1;
                    unique case (phase_reg)
                        i2cmbe_pkg::PH_WRISE:
                        begin
                            enter_ph = i2cmbe_pkg::PH_WHIGH;
                        end
                        i2cmbe_pkg::PH_RRISE:
                        begin
                            if (active_command_reg == i2cmbe_pkg::CMD_READ)
                                shift_data_next = {shift_data_reg[6:0], sda_in};
                            else
                                last_ack_next = sda_in;
                            enter_ph = i2cmbe_pkg::PH_RHIGH;
                        end
                        default:
                        begin
                            enter_ph = i2cmbe_pkg::PH_STOP_HIGH;
                        end
                    endcase
                end
            end

            // timed phases
            default:
            begin
                if (delay_count_reg != 8'd0)
                begin
                    delay_count_next = delay_count_reg - 8'd1;
                end
                else
                begin
                    unique case (phase_reg)
                        i2cmbe_pkg::PH_START_A:
                        begin
                            enter_en = 1'b1;
                            enter_ph = i2cmbe_pkg::PH_START_B;
                        end
                        i2cmbe_pkg::PH_START_B:
                        begin
                            bit_count_next = 4'd0;
                            enter_en       = 1'b1;
                            enter_ph       = i2cmbe_pkg::PH_WLOW;
                        end
                        i2cmbe_pkg::PH_WLOW:
                        begin
                            enter_en = 1'b1;
                            enter_ph = i2cmbe_pkg::PH_WRISE;
                        end
                        i2cmbe_pkg::PH_WHIGH:
                        begin
                            if (active_command_reg == i2cmbe_pkg::CMD_READ)
                            begin
                                phase_next = i2cmbe_pkg::PH_IDLE;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                shift_data_next = {shift_data_reg[6:0], 1'b0};
                                bit_count_next  = bit_count_reg + 4'd1;
                                enter_en        = 1'b1;
                                if (bit_count_next >= i2cmbe_pkg::BITS_PER_BYTE)
                                    enter_ph = i2cmbe_pkg::PH_RLOW;
                                else
                                    enter_ph = i2cmbe_pkg::PH_WLOW;
                            end
                        end
                        i2cmbe_pkg::PH_RLOW:
                        begin
                            enter_en = 1'b1;
                            enter_ph = i2cmbe_pkg::PH_RRISE;
                        end
                        i2cmbe_pkg::PH_RHIGH:
                        begin
                            if (active_command_reg != i2cmbe_pkg::CMD_READ)
                            begin
                                phase_next = i2cmbe_pkg::PH_IDLE;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                bit_count_next = bit_count_reg + 4'd1;
                                enter_en       = 1'b1;
                                if (bit_count_next >= i2cmbe_pkg::BITS_PER_BYTE)
                                begin
                                    rx_hold_next = shift_data_reg;
                                    enter_ph     = i2cmbe_pkg::PH_WLOW;
                                end
                                else
                                begin
                                    enter_ph = i2cmbe_pkg::PH_RLOW;
                                end
                            end
                        end
                        i2cmbe_pkg::PH_STOP_LOW:
                        begin
                            enter_en = 1'b1;
                            enter_ph = i2cmbe_pkg::PH_STOP_RISE;
                        end
                        i2cmbe_pkg::PH_STOP_HIGH:
                        begin
                            enter_en = 1'b1;
                            enter_ph = i2cmbe_pkg::PH_STOP_END;
                        end
                        i2cmbe_pkg::PH_REC_LOW:
                        begin
                            enter_en = 1'b1;
                            enter_ph = i2cmbe_pkg::PH_REC_HIGH;
                        end
                        i2cmbe_pkg::PH_STOP_END, i2cmbe_pkg::PH_REC_HIGH:
                        begin
                            // bus recovery check: pulse scl while sda is held low
                            if (((phase_reg == i2cmbe_pkg::PH_REC_HIGH) ||
                                 (active_command_reg == i2cmbe_pkg::CMD_STOP_REC)) &&
                                !sda_in && (recover_count_reg < recovery_pulses_reg))
                            begin
                                recover_count_next = recover_count_reg + 4'd1;
                                enter_en           = 1'b1;
                                enter_ph           = i2cmbe_pkg::PH_REC_LOW;
                            end
                            else
                            begin
                                phase_next = i2cmbe_pkg::PH_IDLE;
                                done_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = i2cmbe_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
        endcase

        // phase entry actions
        if (enter_en)
        begin
            phase_next = enter_ph;
            wbit = (active_command_next == i2cmbe_pkg::CMD_READ) ? nack_latch_next
                                                                 : shift_data_next[7];
            unique case (enter_ph)
                i2cmbe_pkg::PH_START_A:
                begin
                    sda_drive_next   = 1'b0;
                    scl_drive_next   = 1'b0;
                    delay_count_next = short_load;
                end
                i2cmbe_pkg::PH_START_B:
                begin
                    sda_drive_next   = 1'b1;
                    delay_count_next = short_load;
                end
                i2cmbe_pkg::PH_WLOW:
                begin
                    scl_drive_next   = 1'b1;
                    sda_drive_next   = !wbit;
                    delay_count_next = half_period_reg;
                end
                i2cmbe_pkg::PH_WRISE, i2cmbe_pkg::PH_RRISE, i2cmbe_pkg::PH_STOP_RISE:
                begin
                    scl_drive_next     = 1'b0;
                    stretch_count_next = 8'd0;
                end
                i2cmbe_pkg::PH_WHIGH:
                begin
                    delay_count_next = half_period_reg;
                end
                i2cmbe_pkg::PH_RLOW:
                begin
                    scl_drive_next   = 1'b1;
                    sda_drive_next   = 1'b0;
                    delay_count_next = half_period_reg;
                end
                i2cmbe_pkg::PH_RHIGH, i2cmbe_pkg::PH_STOP_HIGH:
                begin
                    delay_count_next = short_load;
                end
                i2cmbe_pkg::PH_STOP_LOW:
                begin
                    scl_drive_next   = 1'b1;
                    sda_drive_next   = 1'b1;
                    delay_count_next = short_load;
                end
                i2cmbe_pkg::PH_STOP_END:
                begin
                    sda_drive_next   = 1'b0;
                    delay_count_next = short_load;
                end
                i2cmbe_pkg::PH_REC_LOW:
                begin
                    scl_drive_next   = 1'b1;
                    delay_count_next = short_load;
                end
                i2cmbe_pkg::PH_REC_HIGH:
                begin
                    scl_drive_next   = 1'b0;
                    delay_count_next = short_load;
                end
                default:
                begin
                    phase_next = i2cmbe_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // engine state and output register, advanced on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= i2cmbe_pkg::PH_IDLE;
            delay_count_reg    <= 8'd0;
            stretch_count_reg  <= 8'd0;
            bit_count_reg      <= 4'd0;
            shift_data_reg     <= 8'd0;
            recover_count_reg  <= 4'd0;
            active_command_reg <= i2cmbe_pkg::CMD_NONE;
            nack_latch_reg     <= 1'b0;
            sda_drive_reg      <= 1'b0;
            scl_drive_reg      <= 1'b0;
            last_ack_reg       <= 1'b0;
            busy_error_reg     <= 1'b0;
            rx_hold_reg        <= 8'd0;
            m_valid_reg        <= 1'b0;
            m_data_reg         <= 16'd0;
        end
        else if (in_accept)
        begin
            phase_reg          <= phase_next;
            delay_count_reg    <= delay_count_next;
            stretch_count_reg  <= stretch_count_next;
            bit_count_reg      <= bit_count_next;
            shift_data_reg     <= shift_data_next;
            recover_count_reg  <= recover_count_next;
            active_command_reg <= active_command_next;
            nack_latch_reg     <= nack_latch_next;
            sda_drive_reg      <= sda_drive_next;
            scl_drive_reg      <= scl_drive_next;
            last_ack_reg       <= last_ack_next;
            busy_error_reg     <= busy_error_next;
            rx_hold_reg        <= rx_hold_next;
            m_valid_reg        <= 1'b1;
            m_data_reg         <= {2'b00, busy_error_next, last_ack_next, rx_hold_next,
                                   done_next, (phase_next != i2cmbe_pkg::PH_IDLE),
                                   scl_drive_next, sda_drive_next};
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // checks
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[3]) |-> !m_data_reg[2])
        else $error("done reported while still busy");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_axis_tready)
        else $error("tick refused with empty output register");

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= i2cmbe_pkg::BITS_PER_BYTE)
        else $error("bit counter past one byte");

    a_recovery_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == i2cmbe_pkg::PH_REC_LOW) || (phase_reg == i2cmbe_pkg::PH_REC_HIGH))
        |-> (active_command_reg == i2cmbe_pkg::CMD_STOP_REC))
        else $error("recovery pulses outside a recovery stop");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(phase_reg))
        else $error("engine moved without a tick");

endmodule
